@@ sv/iq_nco_mixer_core_macros.svh @@
// Assertion macros for the checker file of the mixer core.
`ifndef IQ_NCO_MIXER_CORE_MACROS_SVH
`define IQ_NCO_MIXER_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define IQM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iq_nco_mixer_core check failed");

// Property checked at every clock edge, reset included.
`define IQM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("iq_nco_mixer_core check failed");

`endif

@@ sv/iqm_pkg.sv @@
// Package with widths, types, the quarter-wave table builder and rounding for the mixer core.
`default_nettype none

package iqm_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 16;
    localparam int PHASE_W     = 32;

    localparam int QTR_BITS  = TABLE_BITS - 2;
    localparam int QTR_DEPTH = (2 ** QTR_BITS) + 1;
    localparam int QADDR_W   = QTR_BITS + 1;
    localparam int MAG_W     = SAMPLE_BITS - 1;
    localparam int PROD_W    = SAMPLE_BITS + DATA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int RSH       = SAMPLE_BITS - 1;
    localparam int Q_W       = SUM_W + 1 - RSH;

    localparam logic [MAG_W-1:0]   AMP      = '1;
    localparam logic [QADDR_W-1:0] QTR_FULL = QADDR_W'(2 ** QTR_BITS);
    localparam logic [SUM_W:0]     RND_HALF = (SUM_W + 1)'(1) << (RSH - 1);
    localparam logic [63:0]        Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0]        HALF_PI  = 64'd1686629713;

    typedef logic [MAG_W-1:0] qtab_t [QTR_DEPTH];

    typedef struct packed {
        logic [QADDR_W-1:0] sin_addr;
        logic [QADDR_W-1:0] cos_addr;
    } rom_req_t;

    typedef struct packed {
        logic [MAG_W-1:0] sin_mag;
        logic [MAG_W-1:0] cos_mag;
    } rom_rsp_t;

    // Sine magnitude at quarter-table position r, scaled to AMP.
    function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned r);
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] mag;
        u  = 64'(r) << (30 - QTR_BITS);
        x  = (u * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 6);
        sq = (x * t) >> 30;
        if (sq > Q30_ONE) begin
            sq = Q30_ONE;
        end
        mag = (sq * 64'(AMP) + (64'd1 << 29)) >> 30;
        if (mag > 64'(AMP)) begin
            mag = 64'(AMP);
        end
        return mag[MAG_W-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int i = 0; i < QTR_DEPTH; i++) begin
            tab[i] = quarter_mag(i);
        end
        return tab;
    endfunction

    // Folds a quadrant and offset onto the quarter table.
    function automatic logic [QADDR_W-1:0] fold_addr(input logic [1:0] quad,
                                                     input logic [QTR_BITS-1:0] r);
        logic [QADDR_W-1:0] r_ext;
        r_ext = {1'b0, r};
        return quad[0] ? (QTR_FULL - r_ext) : r_ext;
    endfunction

    // Rounds half up, drops RSH fraction bits and saturates to DATA_W bits.
    function automatic logic [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W:0] w;
        logic [Q_W-1:0] q;
        w = {v[SUM_W-1], v} + RND_HALF;
        q = w[SUM_W:RSH];
        if ((&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1])) begin
            return q[DATA_W-1:0];
        end else if (q[Q_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/iqm_sine_rom.sv @@
// Quarter-wave sine table with two registered read ports.
`default_nettype none

module iqm_sine_rom
    import iqm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     rd_en,
    input  wire rom_req_t req,
    output rom_rsp_t      rsp
);

    localparam qtab_t QTAB = build_qtab();

    rom_rsp_t rsp_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rsp_reg.sin_mag <= QTAB[req.sin_addr];
            rsp_reg.cos_mag <= QTAB[req.cos_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

@@ sv/iq_nco_mixer_core.sv @@
// Top level of the complex NCO mixer: phase accumulator, sine table read, mix and round.
//
//   channel   | direction | handshake           | beat contents
//   ----------+-----------+---------------------+-----------------------------------
//   s_        | in        | s_valid / s_ready   | s_sample_i, s_sample_q, s_last_in_frame
//   m_        | out       | m_valid / m_ready   | m_out_i, m_out_q
//   cfg_      | in        | cfg_wr_en           | cfg_wr_data (phase step)
//
// One beat is taken per cycle while s_ready is high; a result leaves at m_ after passing the stages below.
// The three stages are table read, multiply and sum with rounding and saturation.
// Each stage moves when it is empty or the next stage moves, so bubbles close up.
// A stalled m_ already lets s_ beats enter until all three stages are full.
// Reset clears the phase, the step and all stage valid flags.
`default_nettype none

module iq_nco_mixer_core
    import iqm_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [PHASE_W-1:0]        cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [DATA_W-1:0]  s_sample_i,
    input  wire logic signed [DATA_W-1:0]  s_sample_q,
    input  wire logic                      s_last_in_frame,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [DATA_W-1:0]       m_out_i,
    output logic signed [DATA_W-1:0]       m_out_q
);

    logic [PHASE_W-1:0] phase_step_reg;
    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] phase_acc_next;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3, s_beat;

    logic                     neg_s1_reg, neg_c1_reg;
    logic signed [DATA_W-1:0] si1_reg, sq1_reg;

    logic signed [PROD_W-1:0] p_si_reg, p_cq_reg, p_sq_reg, p_ci_reg;
    logic signed [DATA_W-1:0] out_i_reg, out_q_reg;

    logic [TABLE_BITS-1:0]     k;
    logic [1:0]                quad_s, quad_c;
    rom_req_t                  rom_req;
    rom_rsp_t                  rom_rsp;
    logic signed [SAMPLE_BITS-1:0] s_val, c_val;
    logic signed [SUM_W-1:0]   sum_i, sum_q;

    assign en3    = !v3_reg || m_ready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign s_ready = en1;
    assign s_beat = s_valid && en1;

    assign k      = phase_acc_reg[PHASE_W-1 -: TABLE_BITS];
    assign quad_s = k[TABLE_BITS-1 -: 2];
    assign quad_c = quad_s + 2'd1;
    assign rom_req.sin_addr = fold_addr(quad_s, k[QTR_BITS-1:0]);
    assign rom_req.cos_addr = fold_addr(quad_c, k[QTR_BITS-1:0]);

    iqm_sine_rom u_rom (
        .aclk  (aclk),
        .rd_en (en1),
        .req   (rom_req),
        .rsp   (rom_rsp)
    );

    always_comb begin
        phase_acc_next = phase_acc_reg;
        if (s_beat) begin
            phase_acc_next = s_last_in_frame ? '0 : phase_acc_reg + phase_step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            phase_acc_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_step_reg <= cfg_wr_data;
            end
            phase_acc_reg <= phase_acc_next;
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            neg_s1_reg <= quad_s[1];
            neg_c1_reg <= quad_c[1];
            si1_reg    <= s_sample_i;
            sq1_reg    <= s_sample_q;
        end
    end

    assign s_val = neg_s1_reg ? -$signed({1'b0, rom_rsp.sin_mag})
                              :  $signed({1'b0, rom_rsp.sin_mag});
    assign c_val = neg_c1_reg ? -$signed({1'b0, rom_rsp.cos_mag})
                              :  $signed({1'b0, rom_rsp.cos_mag});

    always_ff @(posedge aclk) begin
        if (en2) begin
            p_si_reg <= PROD_W'(s_val * si1_reg);
            p_cq_reg <= PROD_W'(c_val * sq1_reg);
            p_sq_reg <= PROD_W'(s_val * sq1_reg);
            p_ci_reg <= PROD_W'(c_val * si1_reg);
        end
    end

    assign sum_i = SUM_W'(p_si_reg) - SUM_W'(p_cq_reg);
    assign sum_q = SUM_W'(p_sq_reg) + SUM_W'(p_ci_reg);

    always_ff @(posedge aclk) begin
        if (en3) begin
            out_i_reg <= round_sat(sum_i);
            out_q_reg <= round_sat(sum_q);
        end
    end

    assign m_valid = v3_reg;
    assign m_out_i = out_i_reg;
    assign m_out_q = out_q_reg;

endmodule

`default_nettype wire

@@ sv/iqm_checker.sv @@
// Port-level checker for the mixer core, bound to the top level.
`default_nettype none
`include "iq_nco_mixer_core_macros.svh"

module iqm_checker
    import iqm_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic signed [DATA_W-1:0] m_out_i,
    input wire logic signed [DATA_W-1:0] m_out_q
);

    localparam logic [2:0] MAX_OUT = 3'd3;

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    // Beats accepted at s_ whose results have not yet left at m_.
    always_comb begin
        cnt_next = cnt_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            cnt_next = cnt_reg + 3'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    property p_out_hold;
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_i) && $stable(m_out_q));
    endproperty

    `IQM_ASSERT(a_ready_only_on_stall, aclk, aresetn, !s_ready |-> (m_valid && !m_ready))
    `IQM_ASSERT(a_out_hold, aclk, aresetn, p_out_hold)
    `IQM_ASSERT(a_no_invented, aclk, aresetn, m_valid |-> (cnt_reg != 3'd0))
    `IQM_ASSERT(a_depth_bound, aclk, aresetn, cnt_reg <= MAX_OUT)
    `IQM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

endmodule

bind iq_nco_mixer_core iqm_checker u_iqm_checker (.*);

`default_nettype wire
